// ===== rtl/core/esp_pkg.sv =====
`timescale 1ns / 1ps

package esp_pkg;

    // operation codes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_SET    = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int unsigned TPS_DEFAULT = 32728;
    localparam int unsigned TPS_MAX     = 1000000;

    // shared divider: 28-bit dividend, divisor wide enough for the largest tick rate
    localparam int DIV_N = 28;
    localparam int DIV_W = $clog2(TPS_MAX + 1);

    localparam int FRAC_W   = 12;
    localparam int POS_W    = 15;
    localparam int OFF_W    = 16;
    localparam int MS_W     = 16;
    localparam int MUL_A_W  = 29;
    localparam int MUL_B_W  = 17;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 72;

    typedef struct packed {
        logic             start;
        logic [DIV_N-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_N-1:0] quot;
    } t_div_rsp;

    function automatic logic on_screen(input logic signed [OFF_W-1:0] x);
        on_screen = (x > -16'sd256) && (x < 16'sd256);
    endfunction

endpackage

// ===== rtl/core/esp_div.sv =====
`timescale 1ns / 1ps

module esp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  esp_pkg::t_div_req i_req,
    output esp_pkg::t_div_rsp o_rsp
);
    import esp_pkg::*;

    localparam int CNT_W = $clog2(DIV_N);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_dvs;
    logic [DIV_N-1:0] r_quo;

    logic [DIV_W:0]   w_trial;
    logic [DIV_W:0]   w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_quo[DIV_N-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
            r_quo <= {r_quo[DIV_N-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("divider done without a run");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !$past(i_req.start)) |-> r_rem < r_dvs)
        else $error("partial remainder out of range");
`endif

endmodule

// ===== rtl/core/eased_scroll_pan.sv =====
`timescale 1ns / 1ps
// a tick during a pan makes two 28-step passes through the shared divider and four uses
//   of the multiplier on its way from input transfer to result
// start, set, unused and non-advancing ticks go from idle straight to the result state
// throughput: one item at a time; the next item is taken once the result is registered
// reset: synchronous active low; position, times and flags clear, visibility flags set

module eased_scroll_pan #(
    parameter int unsigned TICKS_PER_SECOND = esp_pkg::TPS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // elapsed_ticks, target_pos, duration_ms, zero pad
    input  logic [esp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // operation
    input  logic [1:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // cam_pos, first_offset, second_offset, first_visible, second_visible,
    // desk_offset, desk_visible, halfway_pulse, busy_res, zero pad
    output logic [esp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // finished
    output logic                             m_axis_tlast
);
    import esp_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_QDIV   = 14'b00000000000010,
        S_MS_W   = 14'b00000000000100,
        S_MS_ACC = 14'b00000000001000,
        S_TDIV   = 14'b00000000010000,
        S_CRV    = 14'b00000000100000,
        S_P1_W   = 14'b00000001000000,
        S_P1_USE = 14'b00000010000000,
        S_P2_W   = 14'b00000100000000,
        S_P2_USE = 14'b00001000000000,
        S_P3_W   = 14'b00010000000000,
        S_P3_USE = 14'b00100000000000,
        S_VIS    = 14'b01000000000000,
        S_RES    = 14'b10000000000000
    } t_state;

    t_state r_state;

    logic signed [POS_W-1:0]   r_cam;
    logic signed [POS_W-1:0]   r_start;
    logic signed [POS_W-1:0]   r_end;
    logic [MS_W-1:0]           r_done_ms;
    logic [MS_W-1:0]           r_total;
    logic                      r_active;
    logic                      r_past_half;
    logic [2:0]                r_vis;
    logic                      r_pulse;
    logic                      r_fin;

    logic [FRAC_W:0]           r_t;
    logic signed [14:0]        r_f;
    logic                      r_lo;

    logic signed [MUL_A_W-1:0] r_mul_a;
    logic signed [MUL_B_W-1:0] r_mul_b;
    logic signed [PROD_W-1:0]  r_prod;

    logic                      r_out_valid;
    logic [OUT_DATA_W-1:0]     r_out_data;
    logic                      r_out_last;

    t_div_req                  w_div_req;
    t_div_rsp                  w_div_rsp;

    logic                      w_in_acc;
    logic [1:0]                w_op;
    logic [15:0]               w_ticks;
    logic signed [POS_W-1:0]   w_target;
    logic [MS_W-1:0]           w_dur;
    logic                      w_tick_run;

    logic [25:0]               w_ms;
    logic [26:0]               w_sum;
    logic [MS_W-1:0]           n_done_ms;
    logic signed [PROD_W-1:0]  w_sh;
    logic signed [14:0]        w_f;
    logic signed [14:0]        w_d;
    logic signed [OFF_W-1:0]   w_span;
    logic signed [OFF_W-1:0]   n_cam;
    logic signed [OFF_W-1:0]   w_x0;
    logic signed [OFF_W-1:0]   w_x1;
    logic signed [OFF_W-1:0]   w_xd;
    logic signed [OFF_W-1:0]   w_o0;
    logic signed [OFF_W-1:0]   w_o1;
    logic signed [OFF_W-1:0]   w_od;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_op          = s_axis_tuser;
    assign w_ticks       = s_axis_tdata[15:0];
    assign w_target      = $signed(s_axis_tdata[30:16]);
    assign w_dur         = s_axis_tdata[46:31];
    assign w_tick_run    = (w_op == OP_TICK) && r_active && (r_done_ms != r_total);

    // milliseconds from the tick quotient, saturated at the duration
    assign w_ms      = r_prod[37:12];
    assign w_sum     = 27'(r_done_ms) + 27'(w_ms);
    assign n_done_ms = (w_sum < 27'(r_total)) ? w_sum[MS_W-1:0] : r_total;

    assign w_sh   = r_prod >>> FRAC_W;
    assign w_f    = $signed({1'b0, r_t, 1'b0}) - 15'sd8192;
    assign w_d    = r_lo ? w_sh[14:0] : w_sh[14:0] + 15'sd4096;
    assign w_span = OFF_W'(r_end) - OFF_W'(r_start);
    assign n_cam  = OFF_W'(r_start) + w_sh[OFF_W-1:0];

    assign w_x0 = OFF_W'(r_start) - OFF_W'(r_cam);
    assign w_x1 = OFF_W'(r_end) - OFF_W'(r_cam);
    assign w_xd = r_past_half ? w_x1 : w_x0;
    assign w_o0 = r_active ? w_x0 : '0;
    assign w_o1 = r_active ? w_x1 : '0;
    assign w_od = r_active ? w_xd : '0;

    always_comb begin
        w_div_req = '0;
        if (w_in_acc && w_tick_run) begin
            w_div_req.start    = 1'b1;
            w_div_req.dividend = {w_ticks, 12'b0};
            w_div_req.divisor  = DIV_W'(TICKS_PER_SECOND);
        end else if (r_state == S_MS_ACC && r_total != '0) begin
            w_div_req.start    = 1'b1;
            w_div_req.dividend = {n_done_ms, 12'b0};
            w_div_req.divisor  = DIV_W'(r_total);
        end
    end

    esp_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div_req),
        .o_rsp  (w_div_rsp)
    );

    // shared multiplier, operands and product both registered
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(r_mul_a) * PROD_W'(r_mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cam       <= '0;
            r_start     <= '0;
            r_end       <= '0;
            r_done_ms   <= '0;
            r_total     <= '0;
            r_active    <= 1'b0;
            r_past_half <= 1'b0;
            r_vis       <= 3'b111;
            r_pulse     <= 1'b0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (m_axis_tready && r_state != S_RES) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_pulse <= 1'b0;
                        r_fin   <= (w_op == OP_TICK) && r_active && (r_done_ms == r_total);
                        r_state <= w_tick_run ? S_QDIV : S_RES;
                        case (w_op)
                            OP_START: begin
                                r_start     <= r_cam;
                                r_end       <= w_target;
                                r_done_ms   <= '0;
                                r_total     <= w_dur;
                                r_active    <= 1'b1;
                                r_past_half <= 1'b0;
                            end
                            OP_SET: begin
                                r_cam <= w_target;
                            end
                            OP_TICK: begin
                                if (r_active && r_done_ms == r_total) begin
                                    r_active <= 1'b0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_QDIV: begin
                    if (w_div_rsp.done) begin
                        r_mul_a <= $signed({1'b0, w_div_rsp.quot});
                        r_mul_b <= 17'sd1000;
                        r_state <= S_MS_W;
                    end
                end
                S_MS_W: begin
                    r_state <= S_MS_ACC;
                end
                S_MS_ACC: begin
                    r_done_ms <= n_done_ms;
                    if (r_total != '0) begin
                        r_state <= S_TDIV;
                    end else begin
                        r_t     <= '0;
                        r_state <= S_CRV;
                    end
                end
                S_TDIV: begin
                    if (w_div_rsp.done) begin
                        r_t     <= w_div_rsp.quot[FRAC_W:0];
                        r_state <= S_CRV;
                    end
                end
                S_CRV: begin
                    r_f <= w_f;
                    if (r_t[FRAC_W:FRAC_W-1] == 2'b00) begin
                        r_lo    <= 1'b1;
                        r_mul_a <= MUL_A_W'($signed({2'b00, r_t, 2'b00}));
                        r_mul_b <= MUL_B_W'($signed({1'b0, r_t}));
                    end else begin
                        r_lo    <= 1'b0;
                        r_mul_a <= MUL_A_W'(w_f >>> 1);
                        r_mul_b <= MUL_B_W'(w_f);
                    end
                    r_state <= S_P1_W;
                end
                S_P1_W: begin
                    r_state <= S_P1_USE;
                end
                S_P1_USE: begin
                    r_mul_a <= w_sh[MUL_A_W-1:0];
                    r_mul_b <= r_lo ? MUL_B_W'($signed({1'b0, r_t})) : MUL_B_W'(r_f);
                    r_state <= S_P2_W;
                end
                S_P2_W: begin
                    r_state <= S_P2_USE;
                end
                S_P2_USE: begin
                    r_mul_a <= MUL_A_W'(w_span);
                    r_mul_b <= MUL_B_W'(w_d);
                    r_state <= S_P3_W;
                end
                S_P3_W: begin
                    r_state <= S_P3_USE;
                end
                S_P3_USE: begin
                    r_cam <= n_cam[POS_W-1:0];
                    if (r_done_ms >= (r_total >> 1) && !r_past_half) begin
                        r_past_half <= 1'b1;
                        r_pulse     <= 1'b1;
                    end
                    r_state <= S_VIS;
                end
                S_VIS: begin
                    r_vis   <= {on_screen(w_xd), on_screen(w_x1), on_screen(w_x0)};
                    r_state <= S_RES;
                end
                S_RES: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result payload, loaded with the transfer into the output register
    always_ff @(posedge i_clk) begin
        if (r_state == S_RES && (!r_out_valid || m_axis_tready)) begin
            r_out_data <= {4'b0000, r_active, r_pulse, r_vis[2], w_od, r_vis[1], r_vis[0],
                           w_o1, w_o0, r_cam};
            r_out_last <= r_fin;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_done_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done_ms <= r_total)
        else $error("elapsed time beyond duration");
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CRV) |-> (r_t <= 13'd4096))
        else $error("curve input out of range");
    a_pulse_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tlast && m_axis_tdata[66]))
        else $error("halfway and finish on one result");
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> !m_axis_tdata[67])
        else $error("finish reported while pan runs");
`endif

endmodule

// ===== tb/eased_scroll_pan_test.sv =====
`timescale 1ns / 1ps

module eased_scroll_pan_test;

    import esp_pkg::*;

    localparam int unsigned TICK_RATE  = TPS_DEFAULT;
    localparam int          ITEM_COUNT = 1850;

    // fields from the lowest bit up: elapsed_ticks, target_pos, duration_ms, pad
    typedef struct packed {
        logic                    pad;
        logic [15:0]             duration_ms;
        logic signed [14:0]      target_pos;
        logic [15:0]             elapsed_ticks;
    } t_pan_cmd;

    // finished on top, then the tdata fields from the highest down
    typedef struct packed {
        logic                    finished;
        logic                    busy;
        logic                    halfway;
        logic                    desk_visible;
        logic signed [15:0]      desk_offset;
        logic                    second_visible;
        logic                    first_visible;
        logic signed [15:0]      second_offset;
        logic signed [15:0]      first_offset;
        logic signed [14:0]      cam_pos;
    } t_pan_view;

    typedef struct {
        logic [1:0] op;
        t_pan_cmd   cmd;
        bit         known;
        t_pan_view  view;
    } t_stim_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic [1:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tlast;

    eased_scroll_pan DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // camera state mirror
    int          cam_now;
    int          pan_from;
    int          pan_to;
    int unsigned ms_done;
    int unsigned ms_total;
    bit          panning;
    bit          half_seen;
    bit [2:0]    vis_flags;

    t_pan_view   pending_views[$];
    t_stim_row   directed_rows[$];
    int          fail_count;
    int          items_sent;
    bit          no_idle;
    int          sink_hold;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic bit near_screen(input int x);
        return (x > -256) && (x < 256);
    endfunction

    function automatic t_pan_view advance_pan(input logic [1:0] op, input t_pan_cmd cmd);
        t_pan_view v;
        bit        ended;
        longint    q, ms, sum, t, f, a, b, c, d, span;
        int        x0, x1, xd;
        v = '0;
        ended = 1'b0;
        if (op == OP_START) begin
            pan_from  = cam_now;
            pan_to    = int'(cmd.target_pos);
            ms_done   = 0;
            ms_total  = cmd.duration_ms;
            panning   = 1'b1;
            half_seen = 1'b0;
        end else if (op == OP_SET) begin
            cam_now = int'(cmd.target_pos);
        end else if (op == OP_TICK && panning) begin
            if (ms_done == ms_total) begin
                panning = 1'b0;
                ended   = 1'b1;
            end else begin
                q   = (longint'(cmd.elapsed_ticks) << 12) / longint'(TICK_RATE);
                ms  = (q * 1000) >>> 12;
                sum = longint'(ms_done) + ms;
                ms_done = (sum < longint'(ms_total)) ? int'(sum) : ms_total;
                t = 0;
                if (ms_total != 0)
                    t = (longint'(ms_done) << 12) / longint'(ms_total);
                // ease-in-out cubic, floor shifts throughout
                if (t < 2048) begin
                    d = (((4 * t * t) >>> 12) * t) >>> 12;
                end else begin
                    f = 2 * t - 8192;
                    a = (2048 * f) >>> 12;
                    b = (a * f) >>> 12;
                    c = (b * f) >>> 12;
                    d = c + 4096;
                end
                span = longint'(pan_to) - longint'(pan_from);
                cam_now = pan_from + int'((span * d) >>> 12);
                if (ms_done >= (ms_total >> 1) && !half_seen) begin
                    half_seen = 1'b1;
                    v.halfway = 1'b1;
                end
                x0 = pan_from - cam_now;
                x1 = pan_to - cam_now;
                xd = half_seen ? x1 : x0;
                vis_flags = {near_screen(xd), near_screen(x1), near_screen(x0)};
            end
        end
        if (panning && !ended) begin
            v.first_offset  = 16'(pan_from - cam_now);
            v.second_offset = 16'(pan_to - cam_now);
            v.desk_offset   = half_seen ? v.second_offset : v.first_offset;
        end
        v.cam_pos        = 15'(cam_now);
        v.first_visible  = vis_flags[0];
        v.second_visible = vis_flags[1];
        v.desk_visible   = vis_flags[2];
        v.finished       = ended;
        v.busy           = panning;
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_pan_cmd make_cmd(input int ticks, input int target, input int dur);
        t_pan_cmd c;
        c = '0;
        c.elapsed_ticks = 16'(ticks);
        c.target_pos    = 15'(target);
        c.duration_ms   = 16'(dur);
        return c;
    endfunction

    function automatic t_pan_view view_of(input int cam, input int off0, input int off1,
                                          input bit [2:0] vis, input int offd,
                                          input bit fin, input bit busy);
        t_pan_view v;
        v = '0;
        v.cam_pos        = 15'(cam);
        v.first_offset   = 16'(off0);
        v.second_offset  = 16'(off1);
        v.first_visible  = vis[0];
        v.second_visible = vis[1];
        v.desk_offset    = 16'(offd);
        v.desk_visible   = vis[2];
        v.finished       = fin;
        v.busy           = busy;
        return v;
    endfunction

    task automatic add_row(input logic [1:0] op, input t_pan_cmd cmd);
        t_stim_row row;
        row.op    = op;
        row.cmd   = cmd;
        row.known = 1'b0;
        row.view  = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_known_row(input logic [1:0] op, input t_pan_cmd cmd,
                                 input t_pan_view view);
        t_stim_row row;
        row.op    = op;
        row.cmd   = cmd;
        row.known = 1'b1;
        row.view  = view;
        directed_rows.push_back(row);
    endtask

    task automatic send_item(input logic [1:0] op, input t_pan_cmd cmd,
                             input bit known, input t_pan_view view);
        t_pan_view predicted;
        int        gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cmd;
        s_axis_tuser  <= op;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        predicted = advance_pan(op, cmd);
        pending_views.push_back(known ? view : predicted);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send(input logic [1:0] op, input t_pan_cmd cmd);
        send_item(op, cmd, 1'b0, '0);
    endtask

    function automatic int rand_ticks(input int dur);
        int r;
        r = $urandom_range(0, 99);
        if (dur > 5000 && r < 70)
            return $urandom_range(30000, 65535);
        if (r < 10)
            return 0;
        if (r < 70)
            return $urandom_range(100, 1200);
        if (r < 90)
            return $urandom_range(1201, 20000);
        return $urandom_range(0, 65535);
    endfunction

    function automatic int rand_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        if (r < 60)
            return $urandom_range(1, 400);
        if (r < 90)
            return $urandom_range(401, 5000);
        return $urandom_range(0, 65535);
    endfunction

    function automatic int rand_target();
        int v;
        if ($urandom_range(0, 1) == 0)
            return int'($signed(15'($urandom)));
        v = cam_now + $urandom_range(0, 1000) - 500;
        if (v > 16383)
            v = 16383;
        if (v < -16384)
            v = -16384;
        return v;
    endfunction

    task automatic send_noise();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            send(OP_TICK, make_cmd($urandom, $urandom, $urandom));
        else if (r < 80)
            send(OP_SET, make_cmd($urandom, rand_target(), $urandom));
        else if (r < 90)
            send(OP_UNUSED, make_cmd($urandom, $urandom, $urandom));
        else
            send(OP_START, make_cmd($urandom, rand_target(), rand_duration()));
    endtask

    task automatic run_pan();
        int dur;
        int steps;
        int r;
        dur = rand_duration();
        send(OP_START, make_cmd($urandom, rand_target(), dur));
        steps = 0;
        while (panning && steps < 60 && items_sent < ITEM_COUNT) begin
            r = $urandom_range(0, 99);
            if (r < 4)
                send(OP_SET, make_cmd($urandom, rand_target(), $urandom));
            else if (r < 6)
                send(OP_UNUSED, make_cmd($urandom, $urandom, $urandom));
            else
                send(OP_TICK, make_cmd(rand_ticks(dur), $urandom, $urandom));
            steps++;
        end
        // after a finished pan, usually send one more tick while no pan runs
        if (!panning && $urandom_range(0, 3) != 0)
            send(OP_TICK, make_cmd(rand_ticks(dur), $urandom, $urandom));
    endtask

    task automatic report(input string field, input int want, input int got);
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        fail_count++;
    endtask

    task automatic compare_view(input t_pan_view e, input t_pan_view a);
        if (e.cam_pos !== a.cam_pos)
            report("cam_pos", e.cam_pos, a.cam_pos);
        if (e.first_offset !== a.first_offset)
            report("first_offset", e.first_offset, a.first_offset);
        if (e.second_offset !== a.second_offset)
            report("second_offset", e.second_offset, a.second_offset);
        if (e.first_visible !== a.first_visible)
            report("first_visible", e.first_visible, a.first_visible);
        if (e.second_visible !== a.second_visible)
            report("second_visible", e.second_visible, a.second_visible);
        if (e.desk_offset !== a.desk_offset)
            report("desk_offset", e.desk_offset, a.desk_offset);
        if (e.desk_visible !== a.desk_visible)
            report("desk_visible", e.desk_visible, a.desk_visible);
        if (e.halfway !== a.halfway)
            report("halfway_pulse", e.halfway, a.halfway);
        if (e.finished !== a.finished)
            report("finished", e.finished, a.finished);
        if (e.busy !== a.busy)
            report("busy_res", e.busy, a.busy);
    endtask

    // result side: check each transfer, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_views.size() == 0) begin
                $display("%0t: result with none expected, data %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                fail_count++;
            end else begin
                compare_view(pending_views.pop_front(), {m_axis_tlast, m_axis_tdata[67:0]});
            end
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (sink_hold != 0) begin
            sink_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            sink_hold = ($urandom_range(0, 7) == 0) ? pick_gap() : 0;
            m_axis_tready <= (sink_hold == 0);
            if (sink_hold != 0)
                sink_hold--;
        end
    end

    initial begin
        #8ms;
        $display("eased_scroll_pan test failed");
        $finish;
    end

    initial begin
        cam_now       = 0;
        pan_from      = 0;
        pan_to        = 0;
        ms_done       = 0;
        ms_total      = 0;
        panning       = 1'b0;
        half_seen     = 1'b0;
        vis_flags     = 3'b111;
        fail_count    = 0;
        items_sent    = 0;
        no_idle       = 1'b0;
        sink_hold     = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_TICK;
        m_axis_tready = 1'b0;

        // idle after reset, unused code, set to both extremes
        add_known_row(OP_TICK, make_cmd(0, 0, 0), view_of(0, 0, 0, 3'b111, 0, 0, 0));
        add_known_row(OP_UNUSED, make_cmd(65535, -1, 65535),
                      view_of(0, 0, 0, 3'b111, 0, 0, 0));
        add_known_row(OP_SET, make_cmd(0, 16383, 0), view_of(16383, 0, 0, 3'b111, 0, 0, 0));
        add_known_row(OP_SET, make_cmd(0, -16384, 0),
                      view_of(-16384, 0, 0, 3'b111, 0, 0, 0));
        // zero duration: widest span, ends on the first tick
        add_known_row(OP_START, make_cmd(0, 16383, 0),
                      view_of(-16384, 0, 32767, 3'b111, 0, 0, 1));
        add_known_row(OP_TICK, make_cmd(65535, 0, 0),
                      view_of(-16384, 0, 0, 3'b111, 0, 1, 0));
        add_known_row(OP_TICK, make_cmd(65535, 0, 0),
                      view_of(-16384, 0, 0, 3'b111, 0, 0, 0));
        add_known_row(OP_START, make_cmd(0, 0, 65535),
                      view_of(-16384, 0, 16384, 3'b111, 0, 0, 1));
        add_row(OP_TICK, make_cmd(65535, 0, 0));
        // set during a pan is overwritten by the next tick
        add_row(OP_SET, make_cmd(0, 100, 0));
        add_row(OP_TICK, make_cmd(0, 0, 0));
        // one millisecond pan: halfway on the first tick, then full, then finish
        add_row(OP_START, make_cmd(0, -16384, 1));
        add_row(OP_TICK, make_cmd(0, 0, 0));
        add_row(OP_TICK, make_cmd(40, 0, 0));
        add_row(OP_TICK, make_cmd(0, 0, 0));
        // short pan at frame rate, crossing the screen edge
        add_row(OP_SET, make_cmd(0, 0, 0));
        add_row(OP_START, make_cmd(0, 300, 100));
        repeat (8) add_row(OP_TICK, make_cmd(545, 0, 0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].cmd,
                      directed_rows[i].known, directed_rows[i].view);

        while (items_sent < ITEM_COUNT) begin
            no_idle = ($urandom_range(0, 4) == 0);
            repeat (6) begin
                if ($urandom_range(0, 99) < 80)
                    run_pan();
                else
                    send_noise();
            end
        end
        no_idle = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (pending_views.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("eased_scroll_pan test passed");
        else
            $display("eased_scroll_pan test failed");
        $finish;
    end

endmodule
